// ===== design/prf_pkg.sv =====
// Shared types and codes for the per-slot fragment reassembly buffer.
// No dependencies; every other file of the block imports this package.
package prf_pkg;

    // Request codes carried on req_type
    typedef enum logic [2:0] {
        REQ_OPEN   = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_BIT    = 3'd2,
        REQ_READ   = 3'd3,
        REQ_CLOSE  = 3'd4
    } req_t;

    // Controller state: result strobe pending or not
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the result registers for this transfer
        logic open_ok;     // accepted open
        logic append_ok;   // accepted append
        logic drop_pend;   // cancel pending payload writes
        logic store_bit;   // write one payload bit, advance the write pointer
        logic do_read;     // read request on a valid slot
        logic do_close;    // close and clear the slot
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_valid;
        logic fill_zero;
        logic open_fits;
        logic append_fits;
        logic pend_ok;
    } dp_status_t;

    localparam int RESULT_W = 12;

endpackage

// ===== design/prf_ctrl.sv =====
// Controller of the reassembly buffer: decodes requests into datapath commands
// and drives the start/busy/done handshake. Depends on prf_pkg.
module prf_ctrl
    import prf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] req_type,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    // No request ever stalls, so the block never holds off start
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign done   = (state_reg == ST_RESP);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and request decode
    always_comb
    begin
        cmd        = '0;
        state_next = accept ? ST_RESP : ST_IDLE;
        cmd.load   = accept;
        if (accept)
        begin
            case (req_t'(req_type))
                REQ_BIT:
                begin
                    // payload bits ignore slot_number
                    cmd.store_bit = status.pend_ok;
                    cmd.drop_pend = !status.pend_ok;
                end
                REQ_OPEN:
                begin
                    if (status.slot_valid)
                    begin
                        cmd.open_ok   = status.open_fits;
                        cmd.drop_pend = !status.open_fits;
                    end
                end
                REQ_APPEND:
                begin
                    if (status.slot_valid)
                    begin
                        cmd.append_ok = !status.fill_zero && status.append_fits;
                        cmd.drop_pend = !(!status.fill_zero && status.append_fits);
                    end
                end
                REQ_READ:
                begin
                    cmd.do_read = status.slot_valid;
                end
                REQ_CLOSE:
                begin
                    cmd.do_close = status.slot_valid;
                end
                default:
                begin
                    // unknown request: result only
                end
            endcase
        end
    end

endmodule

// ===== design/prf_datapath.sv =====
// Datapath of the reassembly buffer: per-slot fill counts and headers, the
// payload write pointer, the bit memory and the result registers. Uses prf_pkg.
module prf_datapath
    import prf_pkg::*;
#(
    parameter int BUF_BITS  = 4096,
    parameter int NUM_SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [2:0]  slot_number,
    input  logic [11:0] frag_length,
    input  logic        data_bit,
    input  logic [11:0] read_index,
    input  logic        header_given,
    input  logic [1:0]  enc_mode_in,
    input  logic [2:0]  addr_type_in,
    input  logic [23:0] ssi_in,
    output logic        accepted,
    output logic        slot_empty,
    output logic        bit_out,
    output logic [11:0] total_length,
    output logic        header_present,
    output logic [1:0]  enc_mode_out,
    output logic [2:0]  addr_type_out,
    output logic [23:0] ssi_out
);

    localparam int FW     = $clog2(BUF_BITS);
    localparam int CW     = ((FW > RESULT_W) ? FW : RESULT_W) + 1;
    localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DEPTH  = NUM_SLOTS * BUF_BITS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] BUF_A  = ADDR_W'(BUF_BITS);
    localparam logic [CW-1:0]     BUF_C  = CW'(BUF_BITS);
    localparam logic [FW:0]       BUF_P  = (FW + 1)'(BUF_BITS);

    // Per-slot state
    logic [FW-1:0]   fill_reg      [NUM_SLOTS];
    logic            hdr_valid_reg [NUM_SLOTS];
    logic [1:0]      hdr_enc_reg   [NUM_SLOTS];
    logic [2:0]      hdr_addr_reg  [NUM_SLOTS];
    logic [23:0]     hdr_ssi_reg   [NUM_SLOTS];

    // Payload write pointer
    logic [SW-1:0]   wslot_reg, wslot_next;
    logic [FW-1:0]   wpos_reg,  wpos_next;
    logic [11:0]     pend_reg,  pend_next;

    // Bit memory, undefined until written
    logic            mem [DEPTH];
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic            rd_bit_reg;
    logic            rd_gate_reg;

    // Result registers
    logic            accepted_reg;
    logic            empty_reg;
    logic [11:0]     total_reg;
    logic            hp_reg;
    logic [1:0]      enc_reg;
    logic [2:0]      addr_reg;
    logic [23:0]     ssi_reg;

    logic            slot_valid;
    logic [SW-1:0]   ts;
    logic [FW-1:0]   fill_cur;
    logic [CW-1:0]   fill_ext;
    logic [CW-1:0]   fill_sum;
    logic            ridx_ok;
    logic            hp_cur;

    // Slot decode and status
    assign slot_valid = (slot_number >= 3'd1) && (int'(slot_number) <= NUM_SLOTS);
    assign ts         = slot_valid ? SW'(slot_number - 3'd1) : '0;
    assign fill_cur   = fill_reg[ts];
    assign fill_ext   = CW'(fill_cur);
    assign fill_sum   = fill_ext + CW'(frag_length);
    assign ridx_ok    = CW'(read_index) < BUF_C;
    assign hp_cur     = hdr_valid_reg[ts];

    assign status.slot_valid  = slot_valid;
    assign status.fill_zero   = (fill_cur == '0);
    assign status.open_fits   = fill_sum < BUF_C;
    assign status.append_fits = fill_sum < BUF_C;
    assign status.pend_ok     = (pend_reg != '0) && ((FW + 1)'(wpos_reg) < BUF_P);

    // Write pointer update
    always_comb
    begin
        wslot_next = wslot_reg;
        wpos_next  = wpos_reg;
        pend_next  = pend_reg;
        if (cmd.open_ok)
        begin
            wslot_next = ts;
            wpos_next  = '0;
            pend_next  = frag_length;
        end
        else if (cmd.append_ok)
        begin
            wslot_next = ts;
            wpos_next  = fill_cur;
            pend_next  = frag_length;
        end
        else if (cmd.store_bit)
        begin
            wpos_next = wpos_reg + FW'(1);
            pend_next = pend_reg - 12'd1;
        end
        else if (cmd.drop_pend)
        begin
            pend_next = '0;
        end
        else if (cmd.do_close && (wslot_reg == ts))
        begin
            pend_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wslot_reg <= '0;
            wpos_reg  <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            wslot_reg <= wslot_next;
            wpos_reg  <= wpos_next;
            pend_reg  <= pend_next;
        end
    end

    // Fill counts and header valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                fill_reg[i]      <= '0;
                hdr_valid_reg[i] <= 1'b0;
            end
        end
        else if (cmd.open_ok)
        begin
            fill_reg[ts] <= FW'(frag_length);
            if (header_given)
            begin
                hdr_valid_reg[ts] <= 1'b1;
            end
        end
        else if (cmd.append_ok)
        begin
            fill_reg[ts] <= fill_sum[FW-1:0];
        end
        else if (cmd.do_close)
        begin
            fill_reg[ts]      <= '0;
            hdr_valid_reg[ts] <= 1'b0;
        end
    end

    // Header fields, qualified by the valid flag
    always_ff @(posedge clk)
    begin
        if (cmd.open_ok && header_given)
        begin
            hdr_enc_reg[ts]  <= enc_mode_in;
            hdr_addr_reg[ts] <= addr_type_in;
            hdr_ssi_reg[ts]  <= ssi_in;
        end
    end

    // Bit memory: one write port, one registered read port
    assign wr_addr = ADDR_W'(wslot_reg) * BUF_A + ADDR_W'(wpos_reg);
    assign rd_addr = ADDR_W'(ts) * BUF_A + ADDR_W'(read_index);

    always_ff @(posedge clk)
    begin
        if (cmd.store_bit)
        begin
            mem[wr_addr] <= data_bit;
        end
        rd_bit_reg <= mem[rd_addr];
    end

    // Result capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            accepted_reg <= cmd.open_ok || cmd.append_ok;
            empty_reg    <= !slot_valid || (fill_cur == '0);
            rd_gate_reg  <= cmd.do_read && ridx_ok;
            total_reg    <= cmd.do_close ? fill_ext[RESULT_W-1:0] : '0;
            hp_reg       <= cmd.do_close && hp_cur;
            enc_reg      <= (cmd.do_close && hp_cur) ? hdr_enc_reg[ts]  : '0;
            addr_reg     <= (cmd.do_close && hp_cur) ? hdr_addr_reg[ts] : '0;
            ssi_reg      <= (cmd.do_close && hp_cur) ? hdr_ssi_reg[ts]  : '0;
        end
    end

    assign accepted       = accepted_reg;
    assign slot_empty     = empty_reg;
    assign bit_out        = rd_bit_reg && rd_gate_reg;
    assign total_length   = total_reg;
    assign header_present = hp_reg;
    assign enc_mode_out   = enc_reg;
    assign addr_type_out  = addr_reg;
    assign ssi_out        = ssi_reg;

endmodule

// ===== design/per_slot_fragment_reassembly_top.sv =====
// Top level of the per-slot fragment reassembly buffer.
// Instantiates prf_ctrl and prf_datapath; uses prf_pkg.
//
// Usage: every request is one transfer, taken on a clock edge where start is
// high and busy is low. busy never rises, so a request can be issued every
// cycle; each request gives exactly one result, registered onto the result
// ports, with done high for a single cycle. The receiver cannot stall,
// so it must capture the result ports whenever done is high. Throughput is one
// item per clock, set by the bit memory, which takes one payload write and one
// registered read per cycle. The bit memory (NUM_SLOTS x BUF_BITS bits) is not
// cleared by reset; reading a bit that was never written returns an unknown
// value. Fill counts, header flags and the write pointer clear at reset.
module per_slot_fragment_reassembly_top
    import prf_pkg::*;
#(
    parameter int BUF_BITS  = 4096,
    parameter int NUM_SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [2:0]  req_type,
    input  logic [2:0]  slot_number,
    input  logic [11:0] frag_length,
    input  logic        data_bit,
    input  logic [11:0] read_index,
    input  logic        header_given,
    input  logic [1:0]  enc_mode_in,
    input  logic [2:0]  addr_type_in,
    input  logic [23:0] ssi_in,
    output logic        accepted,
    output logic        slot_empty,
    output logic        bit_out,
    output logic [11:0] total_length,
    output logic        header_present,
    output logic [1:0]  enc_mode_out,
    output logic [2:0]  addr_type_out,
    output logic [23:0] ssi_out
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Request decode and handshake
    prf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    // Slot state, bit memory and results
    prf_datapath #(
        .BUF_BITS  (BUF_BITS),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .slot_number    (slot_number),
        .frag_length    (frag_length),
        .data_bit       (data_bit),
        .read_index     (read_index),
        .header_given   (header_given),
        .enc_mode_in    (enc_mode_in),
        .addr_type_in   (addr_type_in),
        .ssi_in         (ssi_in),
        .accepted       (accepted),
        .slot_empty     (slot_empty),
        .bit_out        (bit_out),
        .total_length   (total_length),
        .header_present (header_present),
        .enc_mode_out   (enc_mode_out),
        .addr_type_out  (addr_type_out),
        .ssi_out        (ssi_out)
    );

endmodule

// ===== design/prf_checker.sv =====
// Port-level checks for the reassembly buffer, bound to the top level.
// Depends on the top-level ports and the request codes in prf_pkg.
module prf_checker
    import prf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  req_type,
    input logic [2:0]  slot_number,
    input logic        accepted,
    input logic        slot_empty,
    input logic [11:0] total_length,
    input logic        header_present
);

    // each transfer gives a result in the next cycle
    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("missing result after transfer");

    // no result without a transfer
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without transfer");

    // only open and append can be accepted
    a_accept_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |-> ($past(req_type) == REQ_OPEN || $past(req_type) == REQ_APPEND))
        else $error("accepted set for a request other than open or append");

    // invalid slot zero reports empty and nothing else
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(slot_number) == 3'd0 && $past(req_type) != REQ_BIT)
        |-> (slot_empty && !accepted && total_length == 12'd0 && !header_present))
        else $error("invalid slot produced data");

    // length and header only come back on close
    a_close_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (total_length != 12'd0 || header_present)) |-> ($past(req_type) == REQ_CLOSE))
        else $error("close data on a non-close request");

endmodule

bind per_slot_fragment_reassembly_top prf_checker u_prf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .req_type       (req_type),
    .slot_number    (slot_number),
    .accepted       (accepted),
    .slot_empty     (slot_empty),
    .total_length   (total_length),
    .header_present (header_present)
);

// ===== tb/per_slot_fragment_reassembly_top_tb.sv =====
// Self-checking testbench for per_slot_fragment_reassembly_top.
// Depends on prf_pkg and the block's RTL; a scoreboard class predicts each
// result from its own copy of the slot buffers and headers.
`timescale 1ns / 1ps

module per_slot_fragment_reassembly_top_tb;
    import prf_pkg::*;

    localparam int BUF_BITS      = 4096;
    localparam int NUM_SLOTS     = 4;
    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 5;
    localparam int SETTLE_CYCLES = 4;
    // Highest code the 3-bit request field can carry
    localparam logic [2:0] REQ_CODE_MAX = 3'd7;

    // One request transfer, field for field
    typedef struct packed {
        logic [2:0]  code;
        logic [2:0]  slot;
        logic [11:0] len;
        logic        dbit;
        logic [11:0] ridx;
        logic        hgiven;
        logic [1:0]  enc;
        logic [2:0]  addr;
        logic [23:0] ssi;
    } request_t;

    // One result transfer
    typedef struct packed {
        logic        accepted;
        logic        slot_empty;
        logic        bit_out;
        logic [11:0] total_length;
        logic        header_present;
        logic [1:0]  enc;
        logic [2:0]  addr;
        logic [23:0] ssi;
    } reply_t;

    // Slot buffer model plus the queue of results still to come
    class slot_buffer_scoreboard;
        bit          slot_mem[NUM_SLOTS][BUF_BITS];
        bit          seen_map[NUM_SLOTS][BUF_BITS];
        int          seen_pos[NUM_SLOTS][$];
        int          level[NUM_SLOTS];
        bit          has_hdr[NUM_SLOTS];
        logic [1:0]  enc_r[NUM_SLOTS];
        logic [2:0]  addr_r[NUM_SLOTS];
        logic [23:0] ssi_r[NUM_SLOTS];
        int          wr_slot;
        int          wr_ptr;
        int          wr_left;
        reply_t      awaited_results[$];
        int          errors;

        function new();
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                level[s]   = 0;
                has_hdr[s] = 0;
                enc_r[s]   = '0;
                addr_r[s]  = '0;
                ssi_r[s]   = '0;
            end
            wr_slot = 0;
            wr_ptr  = 0;
            wr_left = 0;
            errors  = 0;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        // Stimulus may only read bits that were written at some point
        function bit pick_written(int ts, output logic [11:0] idx);
            idx = '0;
            if (seen_pos[ts].size() == 0)
                return 0;
            idx = 12'(seen_pos[ts][$urandom_range(0, seen_pos[ts].size() - 1)]);
            return 1;
        endfunction

        // Accepted request: update the model and queue the result it causes
        function void note_request(request_t rq);
            reply_t r;
            bit     valid;
            bit     ok;
            int     ts;
            r     = '0;
            valid = rq.slot >= 3'd1 && int'(rq.slot) <= NUM_SLOTS;
            ts    = valid ? int'(rq.slot) - 1 : 0;
            r.slot_empty = !valid || level[ts] == 0;

            if (rq.code == REQ_BIT)
            begin
                // payload bits follow the last accepted open/append
                if (wr_left != 0 && wr_ptr < BUF_BITS)
                begin
                    slot_mem[wr_slot][wr_ptr] = rq.dbit;
                    if (!seen_map[wr_slot][wr_ptr])
                    begin
                        seen_map[wr_slot][wr_ptr] = 1;
                        seen_pos[wr_slot] = {seen_pos[wr_slot], wr_ptr};
                    end
                    wr_ptr++;
                    wr_left--;
                end
                else
                    wr_left = 0;
            end
            else if (valid)
            begin
                case (rq.code)
                    REQ_OPEN, REQ_APPEND:
                    begin
                        wr_left = 0;
                        if (rq.code == REQ_OPEN)
                        begin
                            ok = level[ts] + int'(rq.len) < BUF_BITS;
                            if (ok)
                            begin
                                level[ts] = int'(rq.len);
                                if (rq.hgiven)
                                begin
                                    has_hdr[ts] = 1;
                                    enc_r[ts]   = rq.enc;
                                    addr_r[ts]  = rq.addr;
                                    ssi_r[ts]   = rq.ssi;
                                end
                                wr_ptr = 0;
                            end
                        end
                        else
                        begin
                            ok = level[ts] != 0 && level[ts] + int'(rq.len) < BUF_BITS;
                            if (ok)
                            begin
                                wr_ptr    = level[ts];
                                level[ts] = level[ts] + int'(rq.len);
                            end
                        end
                        if (ok)
                        begin
                            wr_slot    = ts;
                            wr_left    = int'(rq.len);
                            r.accepted = 1;
                        end
                    end
                    REQ_READ:
                        r.bit_out = slot_mem[ts][rq.ridx];
                    REQ_CLOSE:
                    begin
                        r.total_length = 12'(level[ts]);
                        if (has_hdr[ts])
                        begin
                            r.header_present = 1;
                            r.enc  = enc_r[ts];
                            r.addr = addr_r[ts];
                            r.ssi  = ssi_r[ts];
                        end
                        level[ts]   = 0;
                        has_hdr[ts] = 0;
                        enc_r[ts]   = '0;
                        addr_r[ts]  = '0;
                        ssi_r[ts]   = '0;
                        if (wr_slot == ts)
                            wr_left = 0;
                    end
                    default: ;
                endcase
            end
            awaited_results = {awaited_results, r};
        endfunction

        function void cmp_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
            if (act_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $realtime, name, exp_v, act_v);
            end
        endfunction

        // Result transfer: compare with the oldest awaited result
        function void check_result(reply_t act);
            reply_t exp_r;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing awaited: expected none, actual %h",
                         $realtime, act);
                return;
            end
            exp_r = awaited_results.pop_front();
            cmp_field("accepted",       24'(exp_r.accepted),       24'(act.accepted));
            cmp_field("slot_empty",     24'(exp_r.slot_empty),     24'(act.slot_empty));
            cmp_field("bit_out",        24'(exp_r.bit_out),        24'(act.bit_out));
            cmp_field("total_length",   24'(exp_r.total_length),   24'(act.total_length));
            cmp_field("header_present", 24'(exp_r.header_present), 24'(act.header_present));
            cmp_field("enc_mode_out",   24'(exp_r.enc),            24'(act.enc));
            cmp_field("addr_type_out",  24'(exp_r.addr),           24'(act.addr));
            cmp_field("ssi_out",        exp_r.ssi,                 act.ssi);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [2:0]  req_type;
    logic [2:0]  slot_number;
    logic [11:0] frag_length;
    logic        data_bit;
    logic [11:0] read_index;
    logic        header_given;
    logic [1:0]  enc_mode_in;
    logic [2:0]  addr_type_in;
    logic [23:0] ssi_in;
    logic        accepted;
    logic        slot_empty;
    logic        bit_out;
    logic [11:0] total_length;
    logic        header_present;
    logic [1:0]  enc_mode_out;
    logic [2:0]  addr_type_out;
    logic [23:0] ssi_out;

    slot_buffer_scoreboard sb;
    int n_sent;
    int idle_pct;

    per_slot_fragment_reassembly_top #(
        .BUF_BITS  (BUF_BITS),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .req_type       (req_type),
        .slot_number    (slot_number),
        .frag_length    (frag_length),
        .data_bit       (data_bit),
        .read_index     (read_index),
        .header_given   (header_given),
        .enc_mode_in    (enc_mode_in),
        .addr_type_in   (addr_type_in),
        .ssi_in         (ssi_in),
        .accepted       (accepted),
        .slot_empty     (slot_empty),
        .bit_out        (bit_out),
        .total_length   (total_length),
        .header_present (header_present),
        .enc_mode_out   (enc_mode_out),
        .addr_type_out  (addr_type_out),
        .ssi_out        (ssi_out)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("per_slot_fragment_reassembly_top_tb: FAIL");
        $finish;
    end

    // Monitor: result of the earlier transfer is checked before the new one is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
                sb.check_result({accepted, slot_empty, bit_out, total_length,
                                 header_present, enc_mode_out, addr_type_out, ssi_out});
            if (start && busy === 1'b0)
                sb.note_request({req_type, slot_number, frag_length, data_bit, read_index,
                                 header_given, enc_mode_in, addr_type_in, ssi_in});
        end
    end

    function automatic logic [2:0] invalid_slot();
        int v;
        v = $urandom_range(0, 3);
        return (v == 0) ? 3'd0 : 3'(NUM_SLOTS + v);
    endfunction

    // All fields random; callers override what matters
    function automatic request_t rand_request();
        request_t rq;
        rq.code   = 3'($urandom_range(0, REQ_CODE_MAX));
        rq.slot   = 3'($urandom_range(0, 7));
        rq.len    = 12'($urandom_range(0, BUF_BITS - 1));
        rq.dbit   = 1'($urandom_range(0, 1));
        rq.ridx   = 12'($urandom_range(0, BUF_BITS - 1));
        rq.hgiven = 1'($urandom_range(0, 1));
        rq.enc    = 2'($urandom_range(0, 3));
        rq.addr   = 3'($urandom_range(0, 7));
        rq.ssi    = 24'($urandom_range(0, 24'hFFFFFF));
        return rq;
    endfunction

    // One transfer, then an optional random gap
    task automatic issue(request_t rq);
        @(negedge clk);
        req_type     = rq.code;
        slot_number  = rq.slot;
        frag_length  = rq.len;
        data_bit     = rq.dbit;
        read_index   = rq.ridx;
        header_given = rq.hgiven;
        enc_mode_in  = rq.enc;
        addr_type_in = rq.addr;
        ssi_in       = rq.ssi;
        start        = 1'b1;
        while (busy !== 1'b0)
            @(negedge clk);
        @(posedge clk);
        n_sent++;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
    endtask

    task automatic put(logic [2:0] code, logic [2:0] slot, int len = -1, int ridx = -1);
        request_t rq;
        rq      = rand_request();
        rq.code = code;
        rq.slot = slot;
        if (len >= 0)
            rq.len = 12'(len);
        if (ridx >= 0)
            rq.ridx = 12'(ridx);
        issue(rq);
    endtask

    task automatic put_open(logic [2:0] slot, int len, bit hgiven);
        request_t rq;
        rq        = rand_request();
        rq.code   = REQ_OPEN;
        rq.slot   = slot;
        rq.len    = 12'(len);
        rq.hgiven = hgiven;
        issue(rq);
    endtask

    task automatic put_bits(int n);
        repeat (n) put(REQ_BIT, 3'($urandom_range(0, 7)));
    endtask

    // Read a written bit of the slot, or fall back to an invalid slot
    task automatic put_read(int slot);
        logic [11:0] idx;
        if (sb.pick_written(slot - 1, idx))
            put(REQ_READ, 3'(slot), -1, int'(idx));
        else
            put(REQ_READ, invalid_slot());
    endtask

    // Well-formed reassembly: open, payload, appends, reads, and usually a close
    task automatic run_message();
        int slot;
        int len;
        int nb;
        int sel;
        slot = $urandom_range(1, NUM_SLOTS);
        sel  = $urandom_range(0, 99);
        if (sel < 65)
            len = $urandom_range(1, 24);
        else if (sel < 75)
            len = 0;
        else if (sel < 88)
            len = $urandom_range(100, BUF_BITS - 1);
        else
            len = $urandom_range(0, BUF_BITS - 1);
        put_open(3'(slot), len, 1'($urandom_range(0, 1)));
        if (len <= 24)
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len + $urandom_range(0, 1);
        else
            nb = $urandom_range(0, 20);
        for (int i = 0; i < nb; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                put_read(slot);
            put_bits(1);
        end
        // appends land after the current fill, which may be far into the buffer
        repeat ($urandom_range(0, 2))
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, BUF_BITS - 1)
                                               : $urandom_range(0, 16);
            put(REQ_APPEND, 3'(slot), len);
            put_bits((len <= 16) ? len : $urandom_range(0, 8));
        end
        repeat ($urandom_range(0, 3))
            put_read(($urandom_range(0, 3) == 0) ? $urandom_range(1, NUM_SLOTS) : slot);
        if ($urandom_range(0, 9) < 7)
            put(REQ_CLOSE, 3'(slot));
    endtask

    // Noise: any code, any slot; reads kept to written bits
    task automatic send_noise();
        request_t    rq;
        logic [11:0] idx;
        rq = rand_request();
        if (rq.code == REQ_READ && rq.slot >= 3'd1 && int'(rq.slot) <= NUM_SLOTS)
        begin
            if (sb.pick_written(int'(rq.slot) - 1, idx))
                rq.ridx = idx;
            else
                rq.slot = invalid_slot();
        end
        issue(rq);
    endtask

    // Sender holds off until every awaited result has come
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        int idle_table[5];
        int base;
        sb       = new();
        n_sent   = 0;
        idle_pct = 0;
        idle_table = '{0, 63, 7, 0, 63};
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = '0;
        slot_number  = '0;
        frag_length  = '0;
        data_bit     = 1'b0;
        read_index   = '0;
        header_given = 1'b0;
        enc_mode_in  = '0;
        addr_type_in = '0;
        ssi_in       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty close, invalid slots, dropped bits
        put(REQ_CLOSE, 3'd1);
        put(REQ_OPEN, 3'd0, 5);
        put(REQ_READ, 3'd7, -1, BUF_BITS - 1);
        put_bits(1);
        // open with an all-ones header, payload with a read in between
        begin
            request_t rq;
            rq        = rand_request();
            rq.code   = REQ_OPEN;
            rq.slot   = 3'd1;
            rq.len    = 12'd3;
            rq.hgiven = 1'b1;
            rq.enc    = '1;
            rq.addr   = '1;
            rq.ssi    = '1;
            issue(rq);
        end
        put_bits(2);
        put(REQ_READ, 3'd1, -1, 0);
        put_bits(2);
        // append on an empty slot is refused; a good one continues the buffer
        put(REQ_APPEND, 3'd2, 3);
        put(REQ_APPEND, 3'd1, 2);
        put_bits(2);
        // buffer size boundary: 4095 fits, fill plus length of 4096 does not
        put_open(3'd2, BUF_BITS - 1, 1'b0);
        put(REQ_OPEN, 3'd2, 1);
        put(REQ_APPEND, 3'd2, 0);
        put(REQ_APPEND, 3'd2, 1);
        put(REQ_CLOSE, 3'd2);
        // append deep into the buffer, then close cancels the rest
        put_open(3'd3, 2100, 1'b1);
        put(REQ_APPEND, 3'd3, 6);
        put_bits(2);
        put(REQ_CLOSE, 3'd3);
        put_bits(1);
        put(REQ_READ, 3'd3, -1, 2101);
        // unknown codes
        put(REQ_CLOSE + 3'd1, 3'd1);
        put(REQ_CODE_MAX, 3'd4);
        // reopen without header keeps the stored one
        put_open(3'd1, 2, 1'b0);
        put(REQ_CLOSE, 3'd1);
        drain();

        // Random phases with different sender idling
        base = n_sent;
        for (int ph = 0; ph < 5; ph++)
        begin
            idle_pct = idle_table[ph];
            while (n_sent < base + (ph + 1) * PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 75)
                    run_message();
                else
                    send_noise();
            end
            drain();
        end

        // Settle and finish
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d results never arrived: expected %0d more, actual 0",
                     $realtime, sb.outstanding(), sb.outstanding());
        end
        if (sb.errors == 0)
            $display("per_slot_fragment_reassembly_top_tb: PASS");
        else
            $display("per_slot_fragment_reassembly_top_tb: FAIL");
        $finish;
    end

endmodule
